FILE: rtl/pwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwc_pkg
// Types and constants shared by the polyline window clipper.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int CoordWidth = 24;
  localparam int MaxClipSteps = 8;

  typedef struct packed {
    logic signed [CoordWidth-1:0] vx;
    logic signed [CoordWidth-1:0] vy;
    logic                         starts_line;
  } pwc_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] ax;
    logic signed [CoordWidth-1:0] ay;
    logic signed [CoordWidth-1:0] bx;
    logic signed [CoordWidth-1:0] by;
  } pwc_out_t;

  typedef enum logic [2:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_MODE   = 3'd4
  } pwc_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CODE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DSETUP,
    ST_DMUL,
    ST_DDIV,
    ST_DAPPLY,
    ST_OUT
  } pwc_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } pwc_div_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/polyline_window_clipper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_window_clipper
// Clips consecutive polyline segments to a window, optional y distortion.
// ----------------------------------------------------------------------------
// Usage: vertices arrive as words on in_* (valid/stall). Each vertex closes a
// segment with the previous one unless starts_line is set or no vertex was
// seen since reset. The clipped segment leaves on out_* (valid/stall); a
// rejected segment leaves nothing. Window and mode are written on cfg_* while
// the block is idle.
// Timing: one vertex at a time. A start vertex is only stored; a segment
// inside the window passes the code, setup and output states in mode 0. Each
// clip step runs a 52-bit serial divide unless a term is zero, up to eight
// steps; mode 1 adds one divide per endpoint unless its x or y is zero. The
// shared divider sets the rate. in_stall is high from acceptance until the
// block is idle again and any result word has been taken; the result
// register holds while out_stall is high.
// Reset (rst_n low, synchronous) restores the full window, mode 0 and drops
// the stored vertex.
// ----------------------------------------------------------------------------
module polyline_window_clipper (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pwc_pkg::pwc_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pwc_pkg::pwc_out_t       out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [pwc_pkg::CoordWidth-1:0] cfg_data
);
  import pwc_pkg::*;

  localparam int W  = CoordWidth;
  localparam int DW = W + 2;        // coordinate differences
  localparam int NW = 2 * DW;       // product width
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [19:0] DSCALE = 20'd512000;

  logic signed [W-1:0] xl_r, xh_r, yl_r, yh_r;
  logic                mode_r;
  logic signed [W-1:0] prevx_r, prevy_r;
  logic                havep_r;

  pwc_state_t state_r, state_nxt;
  logic signed [DW-1:0] px_r [2], py_r [2];
  logic signed [DW-1:0] px_nxt [2], py_nxt [2];
  logic [3:0] ca_r, cb_r, ca_nxt, cb_nxt;
  logic [3:0] step_r, step_nxt;
  logic       side_r, side_nxt;   // endpoint being moved / distorted
  logic       xcut_r, xcut_nxt;
  logic signed [DW-1:0] bord_r, bord_nxt;
  logic [DW-1:0] ma_r, mb_r, me_r, ma_nxt, mb_nxt, me_nxt;
  logic       neg_r, neg_nxt, zero_r, zero_nxt;
  logic [NW-1:0] prod_r, prod_nxt;
  logic signed [W-1:0] dy_r [2], dy_nxt [2];
  pwc_out_t   res_r, res_nxt;
  logic       oval_r, oval_nxt;

  logic div_start, div_busy, div_done;
  logic [NW-1:0] quo;

  pwc_divider #(.NUM_W(NW), .DEN_W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(prod_r), .den(me_r), .busy(div_busy), .done(div_done), .quo(quo)
  );

  function automatic logic [3:0] outc(logic signed [DW-1:0] x,
                                      logic signed [DW-1:0] y,
                                      logic signed [W-1:0] xl,
                                      logic signed [W-1:0] xh,
                                      logic signed [W-1:0] yl,
                                      logic signed [W-1:0] yh);
    logic [3:0] c;
    c[0] = x < DW'(xl);
    c[1] = x > DW'(xh);
    c[2] = y < DW'(yl);
    c[3] = y > DW'(yh);
    return c;
  endfunction

  function automatic logic [DW-1:0] magf(logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  assign cfg_ready = (state_r == ST_IDLE) && !oval_r;
  assign in_stall  = !((state_r == ST_IDLE) && !oval_r);
  assign out_valid = oval_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xl_r <= CMIN; xh_r <= CMAX; yl_r <= CMIN; yh_r <= CMAX; mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_LOW:  xl_r <= cfg_data;
        REG_X_HIGH: xh_r <= cfg_data;
        REG_Y_LOW:  yl_r <= cfg_data;
        REG_Y_HIGH: yh_r <= cfg_data;
        REG_MODE:   mode_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prevx_r <= '0; prevy_r <= '0; havep_r <= 1'b0;
    end else if (in_acc) begin
      prevx_r <= in_data.vx; prevy_r <= in_data.vy; havep_r <= 1'b1;
    end
  end

  logic [3:0] c_sel;
  logic signed [DW-1:0] d_sel, n_sel, e_sel, qs;
  logic signed [NW:0] dnum;

  always_comb begin
    state_nxt = state_r;
    px_nxt = px_r; py_nxt = py_r;
    ca_nxt = ca_r; cb_nxt = cb_r;
    step_nxt = step_r; side_nxt = side_r; xcut_nxt = xcut_r;
    bord_nxt = bord_r;
    ma_nxt = ma_r; mb_nxt = mb_r; me_nxt = me_r;
    neg_nxt = neg_r; zero_nxt = zero_r; prod_nxt = prod_r;
    dy_nxt = dy_r; res_nxt = res_r; oval_nxt = oval_r;
    div_start = 1'b0;
    c_sel = (ca_r != 4'd0) ? ca_r : cb_r;
    d_sel = '0; n_sel = '0; e_sel = '0; qs = '0; dnum = '0;
    if (oval_r && !out_stall) oval_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !in_data.starts_line && havep_r) begin
          px_nxt[0] = DW'(prevx_r); py_nxt[0] = DW'(prevy_r);
          px_nxt[1] = DW'(in_data.vx); py_nxt[1] = DW'(in_data.vy);
          step_nxt = '0;
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        ca_nxt = outc(px_r[0], py_r[0], xl_r, xh_r, yl_r, yh_r);
        cb_nxt = outc(px_r[1], py_r[1], xl_r, xh_r, yl_r, yh_r);
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if ((ca_r | cb_r) == 4'd0) begin
          side_nxt = 1'b0;
          state_nxt = mode_r ? ST_DSETUP : ST_OUT;
        end else if ((ca_r & cb_r) != 4'd0 || step_r == 4'(MaxClipSteps)) begin
          state_nxt = ST_IDLE;
        end else begin
          side_nxt = (ca_r == 4'd0);
          xcut_nxt = (c_sel[1:0] != 2'd0);
          if (c_sel[1:0] != 2'd0) begin
            bord_nxt = c_sel[0] ? DW'(xl_r) : DW'(xh_r);
            d_sel = py_r[~side_nxt] - py_r[side_nxt];
            n_sel = bord_nxt - px_r[side_nxt];
            e_sel = px_r[~side_nxt] - px_r[side_nxt];
          end else begin
            bord_nxt = c_sel[2] ? DW'(yl_r) : DW'(yh_r);
            d_sel = px_r[~side_nxt] - px_r[side_nxt];
            n_sel = bord_nxt - py_r[side_nxt];
            e_sel = py_r[~side_nxt] - py_r[side_nxt];
          end
          ma_nxt = magf(d_sel); mb_nxt = magf(n_sel); me_nxt = magf(e_sel);
          neg_nxt = (d_sel[DW-1] ^ n_sel[DW-1]) ^ e_sel[DW-1];
          zero_nxt = (d_sel == '0) || (n_sel == '0) || (e_sel == '0);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt = ma_r * mb_r;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && !div_done && zero_r) begin
          state_nxt = ST_APPLY;
        end else if (!div_busy && !div_done) begin
          div_start = 1'b1;
        end else if (div_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        qs = zero_r ? '0 : (neg_r ? DW'(-quo[DW-1:0]) : DW'(quo[DW-1:0]));
        if (xcut_r) begin
          py_nxt[side_r] = py_r[side_r] + qs;
          px_nxt[side_r] = bord_r;
        end else begin
          px_nxt[side_r] = px_r[side_r] + qs;
          py_nxt[side_r] = bord_r;
        end
        step_nxt = step_r + 1'b1;
        state_nxt = ST_CODE;
      end
      ST_DSETUP: begin
        ma_nxt = magf(py_r[side_r]);
        me_nxt = magf(px_r[side_r]);
        neg_nxt = py_r[side_r][DW-1];
        state_nxt = ST_DMUL;
      end
      ST_DMUL: begin
        prod_nxt = NW'(ma_r) * NW'(DSCALE);
        state_nxt = ST_DDIV;
      end
      ST_DDIV: begin
        if (py_r[side_r] == '0 || px_r[side_r] == '0) begin
          state_nxt = ST_DAPPLY;
        end else if (!div_busy && !div_done) begin
          div_start = 1'b1;
        end else if (div_done) begin
          state_nxt = ST_DAPPLY;
        end
      end
      ST_DAPPLY: begin
        if (py_r[side_r] == '0) begin
          dy_nxt[side_r] = '0;
        end else if (px_r[side_r] == '0) begin
          dy_nxt[side_r] = neg_r ? CMIN : CMAX;
        end else if (!neg_r) begin
          dy_nxt[side_r] = (quo > NW'(CMAX)) ? CMAX : W'(quo);
        end else begin
          dnum = {1'b0, quo};
          dy_nxt[side_r] = (quo > NW'(CMAX) + 1'b1) ? CMIN : W'(-dnum);
        end
        side_nxt = 1'b1;
        state_nxt = side_r ? ST_OUT : ST_DSETUP;
      end
      ST_OUT: begin
        res_nxt.ax = W'(px_r[0]);
        res_nxt.bx = W'(px_r[1]);
        res_nxt.ay = mode_r ? dy_r[0] : W'(py_r[0]);
        res_nxt.by = mode_r ? dy_r[1] : W'(py_r[1]);
        oval_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      step_r  <= step_nxt;
    end
    px_r <= px_nxt; py_r <= py_nxt;
    ca_r <= ca_nxt; cb_r <= cb_nxt;
    side_r <= side_nxt; xcut_r <= xcut_nxt; bord_r <= bord_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; me_r <= me_nxt;
    neg_r <= neg_nxt; zero_r <= zero_nxt; prod_r <= prod_nxt;
    dy_r <= dy_nxt; res_r <= res_nxt;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped under stall");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 4'(MaxClipSteps))
    else $error("clip step count overrun");
endmodule
`default_nettype wire

FILE: rtl/pwc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwc_divider
// Restoring serial divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module pwc_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   busy,
  output logic                   done,
  output logic [NUM_W-1:0]       quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire
